// ----- sv/ipid_pkg.sv -----
package ipid_pkg;

  localparam int PC_W = 4;
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] DIV_STEPS_M1 = CNT_W'(15);

  localparam logic [2:0] REG_SETPOINT        = 3'd0;
  localparam logic [2:0] REG_GAIN            = 3'd1;
  localparam logic [2:0] REG_INTEGRAL_TIME   = 3'd2;
  localparam logic [2:0] REG_SAMPLE_PERIOD   = 3'd3;
  localparam logic [2:0] REG_DERIVATIVE_TIME = 3'd4;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef enum logic [2:0] {
    DIV_NONE,
    DIV_INIT_RD,
    DIV_INIT_RI,
    DIV_SAVE_RI,
    DIV_STEP
  } div_op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_K_P0,
    MUL_K_P1,
    MUL_K_P2,
    MUL_E0_Q0,
    MUL_E1_Q1,
    MUL_E2_Q2
  } mul_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_Q0,
    WB_Q1,
    WB_Q2,
    WB_SUM_LOAD,
    WB_SUM_ADD
  } wb_op_t;

  typedef struct packed {
    div_op_t div_op;
    mul_op_t mul_op;
    wb_op_t  wb_op;
    logic    loop;
    logic    finish;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  localparam ucode_t UC_NOP = '{div_op: DIV_NONE, mul_op: MUL_NONE, wb_op: WB_NONE,
                                loop: 1'b0, finish: 1'b0};

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = UC_NOP;
    case (pc)
      4'd0: begin
        uc.div_op = DIV_INIT_RD;
      end
      4'd1: begin
        uc.div_op = DIV_STEP;
        uc.loop = 1'b1;
      end
      4'd2: begin
        uc.div_op = DIV_INIT_RI;
      end
      4'd3: begin
        uc.div_op = DIV_STEP;
        uc.loop = 1'b1;
      end
      4'd4: begin
        uc.div_op = DIV_SAVE_RI;
        uc.mul_op = MUL_K_P0;
      end
      4'd5: begin
        uc.wb_op = WB_Q0;
        uc.mul_op = MUL_K_P1;
      end
      4'd6: begin
        uc.wb_op = WB_Q1;
        uc.mul_op = MUL_K_P2;
      end
      4'd7: begin
        uc.wb_op = WB_Q2;
        uc.mul_op = MUL_E0_Q0;
      end
      4'd8: begin
        uc.wb_op = WB_SUM_LOAD;
        uc.mul_op = MUL_E1_Q1;
      end
      4'd9: begin
        uc.wb_op = WB_SUM_ADD;
        uc.mul_op = MUL_E2_Q2;
      end
      4'd10: begin
        uc.wb_op = WB_SUM_ADD;
      end
      default: begin
        uc.finish = 1'b1;
      end
    endcase
    return uc;
  endfunction

endpackage

// ----- sv/ipid_divider.sv -----
module ipid_divider (
  input  logic              clk,
  input  ipid_pkg::div_ctrl_t ctrl,
  input  logic [31:0]       dividend,
  input  logic [15:0]       divisor,
  output logic [31:0]       quotient
);
  import ipid_pkg::*;

  logic [15:0] dvs;
  logic [15:0] rem;
  logic [15:0] rem_next;
  logic [31:0] quo;
  logic [31:0] quo_next;
  logic [16:0] t1;
  logic [16:0] t2;
  logic [15:0] r1;
  logic        b1;
  logic        b0;

  always_comb begin
    t1 = {rem, quo[31]};
    b1 = (t1 >= {1'b0, dvs});
    r1 = b1 ? 16'(t1 - {1'b0, dvs}) : t1[15:0];
    t2 = {r1, quo[30]};
    b0 = (t2 >= {1'b0, dvs});
    rem_next = b0 ? 16'(t2 - {1'b0, dvs}) : t2[15:0];
    quo_next = {quo[29:0], b1, b0};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (ctrl.step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

// ----- sv/incremental_pid_controller.sv -----
// Velocity-form PID controller. Each measured_value transaction yields one result
// transaction carrying the saturated error (Q7.8) and the updated, saturated control
// value (Q15.16). A transaction is accepted only while the block is idle; the next one
// can be accepted in the cycle after the result is formed. The work is done by the
// microcode program: two 16-step divisions on the shared two-bit-per-cycle divider
// form Td/T0 and T0/Ti, followed by six multiplies on one shared multiplier that
// build the coefficients and the increment. A stalled output holds the last step and
// delays the next acceptance. The user must keep configuration writes out of a running
// transaction so they take effect on the next one; the block itself does not enforce it.
module incremental_pid_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] measured_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] control_value,
  output logic signed [15:0] error_value
);
  import ipid_pkg::*;

  logic signed [15:0] setpoint;
  logic [15:0]        gain;
  logic [15:0]        integral_time;
  logic [15:0]        sample_period;
  logic [15:0]        derivative_time;

  seq_state_t         state;
  seq_state_t         state_next;
  logic [PC_W-1:0]    pc;
  logic [CNT_W-1:0]   cnt;
  ucode_t             uc;
  logic               running;
  logic               stall;
  logic               advance;
  logic               accept;
  div_ctrl_t          div_ctrl;

  logic [31:0]        div_dividend;
  logic [15:0]        div_divisor;
  logic [31:0]        quotient;

  logic signed [15:0] e0;
  logic signed [15:0] e1;
  logic signed [15:0] e2;
  logic signed [31:0] acc;
  logic signed [16:0] diff;
  logic signed [15:0] err_sat;
  logic [31:0]        rd;
  logic [31:0]        ri;
  logic signed [39:0] q0;
  logic signed [39:0] q1;
  logic signed [39:0] q2;
  logic signed [16:0] mul_a;
  logic signed [39:0] mul_b;
  logic signed [56:0] prod;
  logic signed [56:0] prod_next;
  logic signed [58:0] sum;
  logic signed [58:0] prod_ext;
  logic signed [51:0] acc_total;
  logic signed [31:0] acc_next;

  assign uc = ucode_rom(pc);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint        <= 16'sd1280;
      gain            <= 16'd410;
      integral_time   <= 16'd10;
      sample_period   <= 16'd10;
      derivative_time <= 16'd50;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SETPOINT:        setpoint        <= cfg_data;
        REG_GAIN:            gain            <= cfg_data;
        REG_INTEGRAL_TIME:   integral_time   <= cfg_data;
        REG_SAMPLE_PERIOD:   sample_period   <= cfg_data;
        REG_DERIVATIVE_TIME: derivative_time <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (in_valid) state_next = SEQ_RUN;
      end
      SEQ_RUN: begin
        if (advance && uc.finish) state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == SEQ_IDLE);
    running = (state == SEQ_RUN);
    stall = uc.finish && out_valid && !out_ready;
    advance = running && !stall;
    div_ctrl.load = advance && ((uc.div_op == DIV_INIT_RD) || (uc.div_op == DIV_INIT_RI));
    div_ctrl.step = advance && (uc.div_op == DIV_STEP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      pc <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pc <= '0;
      end else if (advance && !(uc.loop && cnt != '0)) begin
        pc <= pc + PC_W'(1);
      end
      if (div_ctrl.load) begin
        cnt <= DIV_STEPS_M1;
      end else if (advance && uc.loop && cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (advance && uc.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    if (uc.div_op == DIV_INIT_RI) begin
      div_dividend = {sample_period, 16'd0};
      div_divisor = (integral_time == '0) ? 16'd1 : integral_time;
    end else begin
      div_dividend = {derivative_time, 16'd0};
      div_divisor = (sample_period == '0) ? 16'd1 : sample_period;
    end
  end

  ipid_divider u_divider (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient)
  );

  always_comb begin
    diff = {setpoint[15], setpoint} - {measured_value[15], measured_value};
    if (diff[16] != diff[15]) begin
      err_sat = diff[16] ? -16'sd32768 : 16'sd32767;
    end else begin
      err_sat = diff[15:0];
    end
  end

  always_comb begin
    mul_a = {1'b0, gain};
    mul_b = '0;
    case (uc.mul_op)
      MUL_K_P0: mul_b = {8'd0, rd} + 40'sd65536;
      MUL_K_P1: mul_b = {8'd0, ri} - 40'sd65536 - {7'd0, rd, 1'b0};
      MUL_K_P2: mul_b = {8'd0, rd};
      MUL_E0_Q0: begin
        mul_a = {e0[15], e0};
        mul_b = q0;
      end
      MUL_E1_Q1: begin
        mul_a = {e1[15], e1};
        mul_b = q1;
      end
      MUL_E2_Q2: begin
        mul_a = {e2[15], e2};
        mul_b = q2;
      end
      default: mul_b = '0;
    endcase
  end

  assign prod_next = mul_a * mul_b;
  assign prod_ext = {{2{prod[56]}}, prod};

  always_comb begin
    acc_total = {{20{acc[31]}}, acc} + {sum[58], sum[58:8]};
    if (acc_total > 52'sd2147483647) begin
      acc_next = 32'sh7fffffff;
    end else if (acc_total < -52'sd2147483648) begin
      acc_next = 32'sh80000000;
    end else begin
      acc_next = acc_total[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) e0 <= err_sat;
    if (advance) begin
      prod <= prod_next;
      case (uc.div_op)
        DIV_INIT_RI: rd <= quotient;
        DIV_SAVE_RI: ri <= quotient;
        default: ;
      endcase
      case (uc.wb_op)
        WB_Q0:       q0 <= prod[51:12];
        WB_Q1:       q1 <= prod[51:12];
        WB_Q2:       q2 <= prod[51:12];
        WB_SUM_LOAD: sum <= prod_ext;
        WB_SUM_ADD:  sum <= sum + prod_ext;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      e1 <= '0;
      e2 <= '0;
    end else if (advance && uc.finish) begin
      acc <= acc_next;
      e1 <= e0;
      e2 <= e1;
    end
  end

  assign control_value = acc;
  assign error_value = e1;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == SEQ_RUN) && (pc == '0))
    else $error("Accepted transaction did not start the program at step zero.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (running && stall) |=> (state == SEQ_RUN) && $stable(pc) && $stable(acc))
    else $error("Final step advanced while the result register was still occupied.");

  a_loop_count: assert property (@(posedge clk) disable iff (rst)
    (advance && uc.loop && cnt != '0) |=> (cnt == $past(cnt) - CNT_W'(1)) && $stable(pc))
    else $error("Division loop counter or step counter misbehaved.");

endmodule
